@@ rtl/core/c3f_pkg.sv @@
// Shared types and constants for the 3x3 clamped convolution filter.
// Used by the column cells and the top level; depends on nothing else.
package c3f_pkg;

  localparam int unsigned MAX_WIDTH  = 512;
  localparam int unsigned MAX_HEIGHT = 512;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned TAP_N   = 3;
  localparam int unsigned KROW_W  = TAP_N * PIX_W;
  localparam int unsigned DIM_W   = 10;
  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W   = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned WUSE_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HUSE_W  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LINE_W  = 2 * PIX_W;

  localparam int unsigned PROD_W    = 17;
  localparam int unsigned COL_SUM_W = 18;
  localparam int unsigned TOT_W     = 20;

  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned REG_LSB  = 2;
  localparam int unsigned REG_IDX_W = PADDR_W - REG_LSB;

  localparam logic [PIX_W-1:0]  PIX_MAX    = 8'd255;
  localparam logic [KROW_W-1:0] KTOP_RST   = 24'hFF0001;
  localparam logic [KROW_W-1:0] KMID_RST   = 24'hFE0002;
  localparam logic [KROW_W-1:0] KBOT_RST   = 24'hFF0001;
  localparam logic [DIM_W-1:0]  DIM_RST    = 10'd512;
  localparam int unsigned       DIM_MIN    = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_KTOP   = 3'd0,
    REG_KMID   = 3'd1,
    REG_KBOT   = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             flush;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered;
    logic             frame_last;
  } out_item_t;

  typedef logic signed [PIX_W-1:0] tap_t;
  typedef tap_t [TAP_N-1:0] tap_col_t;
  typedef logic [TAP_N-1:0][PIX_W-1:0] pix_col_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic capture;
    logic blank;
    logic sum_en;
  } cell_ctl_t;

endpackage

@@ rtl/core/c3f_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; no package dependency.
module c3f_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 512,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/c3f_cell.sv @@
// One window column cell: three pixels, their kernel products and the column sum.
// Depends on c3f_pkg.
module c3f_cell (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  c3f_pkg::cell_ctl_t                     ctl_i,
  input  c3f_pkg::pix_col_t                      col_i,
  input  c3f_pkg::tap_col_t                      taps_i,
  output c3f_pkg::pix_col_t                      col_o,
  output logic signed [c3f_pkg::COL_SUM_W-1:0]   sum_o
);

  c3f_pkg::pix_col_t col_q, col_d;
  logic signed [c3f_pkg::PROD_W-1:0]    prod_q [c3f_pkg::TAP_N];
  logic signed [c3f_pkg::PROD_W-1:0]    prod_d [c3f_pkg::TAP_N];
  logic signed [c3f_pkg::COL_SUM_W-1:0] sum_q, sum_d;
  logic [c3f_pkg::PIX_W-1:0]            px [c3f_pkg::TAP_N];

  always_comb begin
    col_d = col_q;
    if (ctl_i.clear) begin
      col_d = '0;
    end else if (ctl_i.load) begin
      col_d = col_i;
    end
    for (int k = 0; k < c3f_pkg::TAP_N; k++) begin
      px[k]     = ctl_i.blank ? '0 : col_i[k];
      prod_d[k] = c3f_pkg::PROD_W'($signed(taps_i[k]))
                * c3f_pkg::PROD_W'($signed({1'b0, px[k]}));
    end
    sum_d = c3f_pkg::COL_SUM_W'(prod_q[0]) + c3f_pkg::COL_SUM_W'(prod_q[1])
          + c3f_pkg::COL_SUM_W'(prod_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      for (int k = 0; k < c3f_pkg::TAP_N; k++) begin
        prod_q[k] <= prod_d[k];
      end
    end
    if (ctl_i.sum_en) begin
      sum_q <= sum_d;
    end
  end

  assign col_o = col_q;
  assign sum_o = sum_q;

endmodule

@@ rtl/core/conv3x3_clamped_filter_unit.sv @@
// Top level of the streaming 3x3 clamped convolution filter.
// Depends on c3f_pkg, c3f_ram and c3f_cell.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_stall_o    in_data_i  (c3f_pkg::in_item_t)
//   out      output     out_valid_o / out_stall_i  out_data_o (c3f_pkg::out_item_t)
//   config   input      APB psel/penable/pready    pwdata / prdata, paddr 5 bits
//
// One pixel transaction is taken every clock while in_stall_o is low; the line
// store is one RAM read at the next column's address, so it never limits the rate.
// A result passes the product, sum and output registers after the transaction
// that releases it, which trails its own pixel by one image row plus one pixel.
// Reset clears counters, window and valid flags at once; there is no clearing pass.
// A stalled output holds the pipeline only when every stage is full.
module conv3x3_clamped_filter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  c3f_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output c3f_pkg::out_item_t              out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [c3f_pkg::PADDR_W-1:0]     paddr,
  input  logic [c3f_pkg::PDATA_W-1:0]     pwdata,
  output logic [c3f_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);

  logic [c3f_pkg::KROW_W-1:0] ktop_q, kmid_q, kbot_q;
  logic [c3f_pkg::DIM_W-1:0]  width_q, height_q;
  logic [c3f_pkg::WUSE_W-1:0] w_use;
  logic [c3f_pkg::HUSE_W-1:0] h_use;
  c3f_pkg::reg_idx_e          reg_idx;
  logic                       cfg_wr, cfg_restart;

  logic [c3f_pkg::COL_W-1:0]  col_q, col_d;
  logic [c3f_pkg::ROW_W-1:0]  row_q, row_d;

  logic                       acc, first_col, row_ge1, row_ge2;
  logic                       border, is_last, inner_out, emit;
  logic [c3f_pkg::PIX_W-1:0]  x, top, mid;
  logic [c3f_pkg::LINE_W-1:0] ram_rdata, ram_wdata;
  logic                       ram_we;

  c3f_pkg::pix_col_t          new_col;
  c3f_pkg::pix_col_t          cell_col [c3f_pkg::TAP_N];
  c3f_pkg::pix_col_t          cell_in  [c3f_pkg::TAP_N];
  c3f_pkg::tap_col_t          cell_tap [c3f_pkg::TAP_N];
  c3f_pkg::cell_ctl_t         cell_ctl [c3f_pkg::TAP_N];
  logic signed [c3f_pkg::COL_SUM_W-1:0] cell_sum [c3f_pkg::TAP_N];

  logic                       p_v_q, p_v_d, p_last_q, p_last_d;
  logic                       s_v_q, s_v_d, s_last_q, s_last_d;
  logic                       o_v_q, o_v_d;
  logic                       o_ready, s_free, s_load, p_free;
  c3f_pkg::out_item_t         out_q, out_d;
  logic signed [c3f_pkg::TOT_W-1:0] total;

  // Configuration port.
  assign pready      = 1'b1;
  assign reg_idx     = c3f_pkg::reg_idx_e'(paddr[c3f_pkg::PADDR_W-1:c3f_pkg::REG_LSB]);
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign cfg_restart = cfg_wr && (reg_idx == c3f_pkg::REG_WIDTH ||
                                  reg_idx == c3f_pkg::REG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ktop_q   <= c3f_pkg::KTOP_RST;
      kmid_q   <= c3f_pkg::KMID_RST;
      kbot_q   <= c3f_pkg::KBOT_RST;
      width_q  <= c3f_pkg::DIM_RST;
      height_q <= c3f_pkg::DIM_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        c3f_pkg::REG_KTOP:   ktop_q   <= pwdata[c3f_pkg::KROW_W-1:0];
        c3f_pkg::REG_KMID:   kmid_q   <= pwdata[c3f_pkg::KROW_W-1:0];
        c3f_pkg::REG_KBOT:   kbot_q   <= pwdata[c3f_pkg::KROW_W-1:0];
        c3f_pkg::REG_WIDTH:  width_q  <= pwdata[c3f_pkg::DIM_W-1:0];
        c3f_pkg::REG_HEIGHT: height_q <= pwdata[c3f_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      c3f_pkg::REG_KTOP:   prdata = c3f_pkg::PDATA_W'(ktop_q);
      c3f_pkg::REG_KMID:   prdata = c3f_pkg::PDATA_W'(kmid_q);
      c3f_pkg::REG_KBOT:   prdata = c3f_pkg::PDATA_W'(kbot_q);
      c3f_pkg::REG_WIDTH:  prdata = c3f_pkg::PDATA_W'(width_q);
      c3f_pkg::REG_HEIGHT: prdata = c3f_pkg::PDATA_W'(height_q);
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    if (32'(width_q) < c3f_pkg::DIM_MIN) begin
      w_use = c3f_pkg::WUSE_W'(c3f_pkg::DIM_MIN);
    end else if (32'(width_q) > c3f_pkg::MAX_WIDTH) begin
      w_use = c3f_pkg::WUSE_W'(c3f_pkg::MAX_WIDTH);
    end else begin
      w_use = c3f_pkg::WUSE_W'(width_q);
    end
    if (32'(height_q) < c3f_pkg::DIM_MIN) begin
      h_use = c3f_pkg::HUSE_W'(c3f_pkg::DIM_MIN);
    end else if (32'(height_q) > c3f_pkg::MAX_HEIGHT) begin
      h_use = c3f_pkg::HUSE_W'(c3f_pkg::MAX_HEIGHT);
    end else begin
      h_use = c3f_pkg::HUSE_W'(height_q);
    end
  end

  // Pipeline handshake.
  assign o_ready    = !o_v_q || !out_stall_i;
  assign s_free     = !s_v_q || o_ready;
  assign s_load     = p_v_q && s_free;
  assign p_free     = !p_v_q || s_load;
  assign in_stall_o = !p_free;
  assign acc        = in_valid_i && !in_stall_o;

  // Stream position decode.
  always_comb begin
    first_col = (col_q == '0);
    row_ge1   = (row_q != '0);
    row_ge2   = (32'(row_q) >= 32'd2);
    border    = first_col && row_ge2;
    is_last   = border && (32'(row_q) > 32'(h_use));
    inner_out = !first_col && row_ge1 && (32'(row_q) <= 32'(h_use));
    emit      = border || inner_out;
    x   = (in_data_i.flush || 32'(row_q) >= 32'(h_use)) ? '0 : in_data_i.pixel;
    top = row_ge2 ? ram_rdata[c3f_pkg::LINE_W-1:c3f_pkg::PIX_W] : '0;
    mid = row_ge1 ? ram_rdata[c3f_pkg::PIX_W-1:0] : '0;
    new_col   = {x, mid, top};
    ram_we    = acc && !is_last;
    ram_wdata = {mid, x};
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_restart) begin
      col_d = '0;
      row_d = '0;
    end else if (acc) begin
      if (is_last) begin
        col_d = '0;
        row_d = '0;
      end else if (32'(col_q) + 32'd1 >= 32'(w_use)) begin
        col_d = '0;
        row_d = row_q + c3f_pkg::ROW_W'(1);
      end else begin
        col_d = col_q + c3f_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  c3f_ram #(
    .Width (c3f_pkg::LINE_W),
    .Depth (c3f_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q),
    .wdata_i (ram_wdata),
    .raddr_i (col_d),
    .rdata_o (ram_rdata)
  );

  // Window cells; the highest index holds the right column.
  always_comb begin
    for (int j = 0; j < c3f_pkg::TAP_N; j++) begin
      cell_in[j]     = (j == c3f_pkg::TAP_N - 1) ? new_col
                                                 : cell_col[(j + 1) % c3f_pkg::TAP_N];
      cell_tap[j][0] = c3f_pkg::tap_t'(ktop_q[j*c3f_pkg::PIX_W +: c3f_pkg::PIX_W]);
      cell_tap[j][1] = c3f_pkg::tap_t'(kmid_q[j*c3f_pkg::PIX_W +: c3f_pkg::PIX_W]);
      cell_tap[j][2] = c3f_pkg::tap_t'(kbot_q[j*c3f_pkg::PIX_W +: c3f_pkg::PIX_W]);
      cell_ctl[j]         = '0;
      cell_ctl[j].sum_en  = s_load;
      if (cfg_restart) begin
        cell_ctl[j].clear = 1'b1;
      end else if (acc) begin
        if (is_last) begin
          cell_ctl[j].clear   = 1'b1;
          cell_ctl[j].capture = 1'b1;
          cell_ctl[j].blank   = (j == c3f_pkg::TAP_N - 1);
        end else if (first_col) begin
          cell_ctl[j].clear   = (j != c3f_pkg::TAP_N - 1);
          cell_ctl[j].load    = (j == c3f_pkg::TAP_N - 1);
          cell_ctl[j].capture = border;
          cell_ctl[j].blank   = (j == c3f_pkg::TAP_N - 1);
        end else begin
          cell_ctl[j].load    = 1'b1;
          cell_ctl[j].capture = inner_out;
        end
      end
    end
  end

  for (genvar g = 0; g < c3f_pkg::TAP_N; g++) begin : g_cell
    c3f_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (cell_ctl[g]),
      .col_i  (cell_in[g]),
      .taps_i (cell_tap[g]),
      .col_o  (cell_col[g]),
      .sum_o  (cell_sum[g])
    );
  end

  // Valid flags, final sum and clamp.
  always_comb begin
    p_v_d    = p_v_q;
    p_last_d = p_last_q;
    if (p_free) begin
      p_v_d    = acc && emit;
      p_last_d = is_last;
    end
    s_v_d    = s_v_q;
    s_last_d = s_last_q;
    if (s_free) begin
      s_v_d    = p_v_q;
      s_last_d = p_last_q;
    end
    o_v_d = o_v_q;
    out_d = out_q;
    total = c3f_pkg::TOT_W'(cell_sum[0]) + c3f_pkg::TOT_W'(cell_sum[1])
          + c3f_pkg::TOT_W'(cell_sum[2]);
    if (o_ready) begin
      o_v_d = s_v_q;
      out_d.frame_last = s_last_q;
      if (total[c3f_pkg::TOT_W-1]) begin
        out_d.filtered = '0;
      end else if (total > $signed(c3f_pkg::TOT_W'(c3f_pkg::PIX_MAX))) begin
        out_d.filtered = c3f_pkg::PIX_MAX;
      end else begin
        out_d.filtered = total[c3f_pkg::PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q    <= 1'b0;
      p_last_q <= 1'b0;
      s_v_q    <= 1'b0;
      s_last_q <= 1'b0;
      o_v_q    <= 1'b0;
    end else begin
      p_v_q    <= p_v_d;
      p_last_q <= p_last_d;
      s_v_q    <= s_v_d;
      s_last_q <= s_last_d;
      o_v_q    <= o_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = o_v_q;
  assign out_data_o  = out_q;

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < 32'(w_use))
    else $error("column counter beyond image width");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_q) <= 32'(h_use) + 32'd1)
    else $error("row counter beyond frame end");

  a_last_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && is_last |=> col_q == '0 && row_q == '0)
    else $error("frame end transaction did not restart the frame");

  a_ram_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> col_q != col_d)
    else $error("line store written at the address being read");

endmodule
